// File: rtl/brfs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bond-reduced force spread: shared types and constants
// Item and result formats, the per-atom sum triple and command codes.
// ----------------------------------------------------------------------------
package brfs_pkg;

    localparam int ATOM_COUNT = 4096;
    localparam int ATOM_W     = $clog2(ATOM_COUNT);
    localparam int FORCE_W    = 64;
    localparam int FACTOR_W   = 17;

    // Unsigned Q16 one.
    localparam logic [FACTOR_W-1:0] Q16_ONE = FACTOR_W'(65536);

    localparam logic CMD_SPREAD = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    typedef struct packed {
        logic                       cmd;
        logic [ATOM_W-1:0]          atom_index;
        logic [ATOM_W-1:0]          partner_index;
        logic [FACTOR_W-1:0]        keep_factor;
        logic signed [FORCE_W-1:0]  force_x;
        logic signed [FORCE_W-1:0]  force_y;
        logic signed [FORCE_W-1:0]  force_z;
    } item_t;

    typedef struct packed {
        logic [ATOM_W-1:0]          read_index;
        logic signed [FORCE_W-1:0]  sum_x;
        logic signed [FORCE_W-1:0]  sum_y;
        logic signed [FORCE_W-1:0]  sum_z;
    } result_t;

    typedef struct packed {
        logic signed [FORCE_W-1:0]  x;
        logic signed [FORCE_W-1:0]  y;
        logic signed [FORCE_W-1:0]  z;
    } sums_t;

    // Memory port controls from the sequencer to the sum store.
    typedef struct packed {
        logic               rd_en;
        logic [ATOM_W-1:0]  rd_addr;
        logic               wr_en;
        logic [ATOM_W-1:0]  wr_addr;
        sums_t              wr_data;
    } mem_ctl_t;

endpackage

`default_nettype wire

// File: rtl/brfs_scale.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Q16 scaling pipeline
// Four-stage product trunc(value * factor / 65536), rounded toward zero.
// ----------------------------------------------------------------------------
module brfs_scale
    import brfs_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic signed [FORCE_W-1:0]  value,
    input  wire logic [FACTOR_W-1:0]        factor,
    output logic signed [FORCE_W-1:0]       scaled
);

    localparam int HALF_W = FORCE_W / 2;
    localparam int PROD_W = HALF_W + FACTOR_W;
    localparam int SUM_W  = FORCE_W + FACTOR_W;

    logic                   neg1_reg;
    logic [FORCE_W-1:0]     mag_reg;
    logic [FACTOR_W-1:0]    factor_reg;
    logic                   neg2_reg;
    logic [PROD_W-1:0]      hi_prod_reg;
    logic [PROD_W-1:0]      lo_prod_reg;
    logic                   neg3_reg;
    logic [FORCE_W-1:0]     res_reg;
    logic [FORCE_W-1:0]     scaled_reg;

    logic [FORCE_W-1:0]     mag_next;
    logic [SUM_W-1:0]       full_sum;

    always_comb
    begin
        mag_next = value[FORCE_W-1] ? FORCE_W'(~value + FORCE_W'(1)) : FORCE_W'(value);
        // The high partial product sits 32 bits up; the Q16 shift drops the low 16 bits.
        full_sum = {hi_prod_reg, {HALF_W{1'b0}}} + SUM_W'(lo_prod_reg);
    end

    always_ff @(posedge clk)
    begin
        neg1_reg    <= value[FORCE_W-1];
        mag_reg     <= mag_next;
        factor_reg  <= factor;
        neg2_reg    <= neg1_reg;
        hi_prod_reg <= PROD_W'(mag_reg[FORCE_W-1:HALF_W]) * PROD_W'(factor_reg);
        lo_prod_reg <= PROD_W'(mag_reg[HALF_W-1:0]) * PROD_W'(factor_reg);
        neg3_reg    <= neg2_reg;
        res_reg     <= full_sum[FORCE_W+15:16];
        scaled_reg  <= neg3_reg ? FORCE_W'(~res_reg + FORCE_W'(1)) : res_reg;
    end

    assign scaled = scaled_reg;

endmodule

`default_nettype wire

// File: rtl/brfs_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Force sum store
// One synchronous memory of x, y, z sums per atom, one read and one write port.
// ----------------------------------------------------------------------------
module brfs_store
    import brfs_pkg::*;
(
    input  wire logic       clk,
    input  wire mem_ctl_t   ctl,
    output sums_t           rd_data
);

    sums_t mem [ATOM_COUNT];
    sums_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[ctl.wr_addr] <= ctl.wr_data;
        end
        // Read data holds while no read is issued.
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[ctl.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/bond_reduced_force_spread.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bond-reduced force spread
// Accumulates split bond forces per atom and reads out and clears the sums.
// ----------------------------------------------------------------------------
// After reset the block clears its sum memory, one atom per cycle, and stalls
// the item channel meanwhile. Each later item keeps the item channel stalled
// until it is done, and a read item also while a pending result stays
// stalled. Their pace is set by the single read port and single write port
// of the sum memory, which each item visits once per atom, and by the
// four-stage Q16 scaling pipeline that produces the shares before they are
// added. Spread items return nothing; a read item returns the atom's sums and
// leaves them at zero. The result sits in an output register, so a new item
// is taken while a result waits.
module bond_reduced_force_spread
    import brfs_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   item_valid,
    output logic        item_stall,
    input  wire item_t  item,
    output logic        result_valid,
    input  wire logic   result_stall,
    output result_t     result
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SPREAD,
        S_READ,
        S_DRAIN
    } state_t;

    localparam logic [2:0] STEP_RD_ATOM    = 3'd0;
    localparam logic [2:0] STEP_RD_PARTNER = 3'd1;
    localparam logic [2:0] STEP_WR_ATOM    = 3'd4;
    localparam logic [2:0] STEP_WR_PARTNER = 3'd5;

    localparam logic [ATOM_W-1:0] ATOM_LAST = ATOM_W'(ATOM_COUNT - 1);

    state_t             state_reg;
    logic [2:0]         step_reg;
    logic [ATOM_W-1:0]  clr_reg;
    logic               out_valid_reg;
    result_t            result_reg;
    item_t              item_reg;
    logic [FACTOR_W-1:0] keep_reg;
    logic [FACTOR_W-1:0] rest_reg;
    logic               same_reg;
    sums_t              atom_sum_reg;

    mem_ctl_t           mem_ctl;
    sums_t              rd_data;
    logic               out_free;
    logic [FACTOR_W-1:0] keep_sat;
    logic [FACTOR_W-1:0] keep_eff;

    logic signed [FORCE_W-1:0] force_arr [3];
    logic signed [FORCE_W-1:0] kept_arr  [3];
    logic signed [FORCE_W-1:0] rest_arr  [3];

    assign force_arr[0] = item_reg.force_x;
    assign force_arr[1] = item_reg.force_y;
    assign force_arr[2] = item_reg.force_z;

    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        brfs_scale u_keep
        (
            .clk    (clk),
            .value  (force_arr[a]),
            .factor (keep_reg),
            .scaled (kept_arr[a])
        );

        brfs_scale u_rest
        (
            .clk    (clk),
            .value  (force_arr[a]),
            .factor (rest_reg),
            .scaled (rest_arr[a])
        );
    end

    brfs_store u_store
    (
        .clk     (clk),
        .ctl     (mem_ctl),
        .rd_data (rd_data)
    );

    assign out_free = !out_valid_reg || !result_stall;

    // A self-bond keeps the whole force, which the full factor reproduces exactly.
    always_comb
    begin
        keep_sat = (item.keep_factor > Q16_ONE) ? Q16_ONE : item.keep_factor;
        keep_eff = (item.partner_index == item.atom_index) ? Q16_ONE : keep_sat;
    end

    always_comb
    begin
        mem_ctl         = '0;
        mem_ctl.rd_addr = item_reg.atom_index;
        mem_ctl.wr_addr = item_reg.atom_index;
        case (state_reg)
            S_CLEAR:
            begin
                mem_ctl.wr_en   = 1'b1;
                mem_ctl.wr_addr = clr_reg;
            end
            S_SPREAD:
            begin
                case (step_reg)
                    STEP_RD_ATOM:
                    begin
                        mem_ctl.rd_en = 1'b1;
                    end
                    STEP_RD_PARTNER:
                    begin
                        mem_ctl.rd_en   = 1'b1;
                        mem_ctl.rd_addr = item_reg.partner_index;
                    end
                    STEP_WR_ATOM:
                    begin
                        mem_ctl.wr_en     = 1'b1;
                        mem_ctl.wr_data.x = atom_sum_reg.x + kept_arr[0];
                        mem_ctl.wr_data.y = atom_sum_reg.y + kept_arr[1];
                        mem_ctl.wr_data.z = atom_sum_reg.z + kept_arr[2];
                    end
                    STEP_WR_PARTNER:
                    begin
                        mem_ctl.wr_en     = !same_reg;
                        mem_ctl.wr_addr   = item_reg.partner_index;
                        mem_ctl.wr_data.x = rd_data.x + rest_arr[0];
                        mem_ctl.wr_data.y = rd_data.y + rest_arr[1];
                        mem_ctl.wr_data.z = rd_data.z + rest_arr[2];
                    end
                    default:
                    begin
                        mem_ctl.rd_en = 1'b0;
                    end
                endcase
            end
            S_READ:
            begin
                mem_ctl.rd_en = 1'b1;
            end
            S_DRAIN:
            begin
                // Clear the entry in the same cycle its sums move to the output.
                mem_ctl.wr_en = out_free;
            end
            default:
            begin
                mem_ctl.rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            step_reg      <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // In the drain state a finished transfer is replaced by the new result.
            if (result_valid && !result_stall && (state_reg != S_DRAIN))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + ATOM_W'(1);
                    if (clr_reg == ATOM_LAST)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        item_reg  <= item;
                        keep_reg  <= keep_eff;
                        rest_reg  <= Q16_ONE - keep_eff;
                        same_reg  <= (item.partner_index == item.atom_index);
                        step_reg  <= '0;
                        state_reg <= (item.cmd == CMD_READ) ? S_READ : S_SPREAD;
                    end
                end
                S_SPREAD:
                begin
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == STEP_RD_PARTNER)
                    begin
                        atom_sum_reg <= rd_data;
                    end
                    if (step_reg == STEP_WR_PARTNER)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_DRAIN;
                end
                S_DRAIN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg         <= 1'b1;
                        result_reg.read_index <= item_reg.atom_index;
                        result_reg.sum_x      <= rd_data.x;
                        result_reg.sum_y      <= rd_data.y;
                        result_reg.sum_z      <= rd_data.z;
                        state_reg             <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = result_reg;

    // A new result is only loaded from the drain state.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == S_DRAIN))
        else $error("result loaded outside the drain state");

    // Reads and writes of the sum memory never meet on one entry.
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_ctl.rd_en && mem_ctl.wr_en && (mem_ctl.rd_addr == mem_ctl.wr_addr)))
        else $error("sum memory read and write hit the same entry");

    // No result can be pending while the memory is still being cleared.
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !result_valid)
        else $error("result present during the clearing pass");

endmodule

`default_nettype wire

// File: bench/force_sum_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Force sum checker
// Watches both channels of the force spreader. It keeps its own copy of the
// per-atom sums, predicts each read-out and compares it field by field.
// ----------------------------------------------------------------------------
module force_sum_checker
    import brfs_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    input  wire logic    item_stall,
    input  wire item_t   item,
    input  wire logic    result_valid,
    input  wire logic    result_stall,
    input  wire result_t result,
    output int           errors,
    output int           pending
);

    sums_t   atom_sums [ATOM_COUNT];
    result_t owed_reads [$];

    initial
    begin
        errors  = 0;
        pending = 0;
        foreach (atom_sums[i])
            atom_sums[i] = '0;
    end

    // Exact product of the magnitude, shifted down, then given the sign back.
    function automatic logic [FORCE_W-1:0] share_of(logic [FORCE_W-1:0] f,
                                                    logic [FACTOR_W-1:0] k);
        logic [FORCE_W-1:0]   mag;
        logic [2*FORCE_W-1:0] prod;
        mag  = f[FORCE_W-1] ? -f : f;
        prod = {{FORCE_W{1'b0}}, mag} * {{(2*FORCE_W-FACTOR_W){1'b0}}, k};
        return f[FORCE_W-1] ? -prod[FORCE_W+15:16] : prod[FORCE_W+15:16];
    endfunction

    task automatic add_force(int idx, logic [FORCE_W-1:0] x, logic [FORCE_W-1:0] y,
                             logic [FORCE_W-1:0] z);
        if (idx < ATOM_COUNT)
        begin
            atom_sums[idx].x = atom_sums[idx].x + x;
            atom_sums[idx].y = atom_sums[idx].y + y;
            atom_sums[idx].z = atom_sums[idx].z + z;
        end
    endtask

    task automatic report(string what, logic [FORCE_W-1:0] got, logic [FORCE_W-1:0] want);
        errors = errors + 1;
        $display("%0t: mismatch in %s: got %h, expected %h", $time, what, got, want);
    endtask

    always @(posedge clk)
    begin
        result_t             want;
        logic [FACTOR_W-1:0] keep;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (owed_reads.size() == 0)
                    report("unrequested result, read_index", result.read_index, '0);
                else
                begin
                    want = owed_reads.pop_front();
                    if (result.read_index !== want.read_index)
                        report("read_index", result.read_index, want.read_index);
                    if (result.sum_x !== want.sum_x)
                        report("sum_x", result.sum_x, want.sum_x);
                    if (result.sum_y !== want.sum_y)
                        report("sum_y", result.sum_y, want.sum_y);
                    if (result.sum_z !== want.sum_z)
                        report("sum_z", result.sum_z, want.sum_z);
                end
            end
            if (item_valid && !item_stall)
            begin
                if (item.cmd == CMD_READ)
                begin
                    want.read_index = item.atom_index;
                    want.sum_x      = atom_sums[item.atom_index].x;
                    want.sum_y      = atom_sums[item.atom_index].y;
                    want.sum_z      = atom_sums[item.atom_index].z;
                    atom_sums[item.atom_index] = '0;
                    owed_reads.push_back(want);
                end
                else if (item.partner_index != item.atom_index)
                begin
                    keep = (item.keep_factor > Q16_ONE) ? Q16_ONE : item.keep_factor;
                    add_force(item.partner_index,
                              share_of(item.force_x, Q16_ONE - keep),
                              share_of(item.force_y, Q16_ONE - keep),
                              share_of(item.force_z, Q16_ONE - keep));
                    add_force(item.atom_index,
                              share_of(item.force_x, keep),
                              share_of(item.force_y, keep),
                              share_of(item.force_z, keep));
                end
                else
                    add_force(item.atom_index, item.force_x, item.force_y, item.force_z);
            end
            pending <= owed_reads.size();
        end
    end

endmodule

// File: bench/bond_reduced_force_spread_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bond-reduced force spread testbench
// Drives directed and random spread and read transfers with random gaps and
// output stalls; the checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module bond_reduced_force_spread_test;
    import brfs_pkg::*;

    localparam int RANDOM_ITEMS = 630;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam logic [FORCE_W-1:0] F_MAX = {1'b0, {(FORCE_W-1){1'b1}}};
    localparam logic [FORCE_W-1:0] F_MIN = {1'b1, {(FORCE_W-1){1'b0}}};
    localparam logic [FORCE_W-1:0] F_ONES = '1;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;
    logic    calm;
    int      errors;
    int      pending;
    int      cycles = 0;

    bond_reduced_force_spread u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    force_sum_checker u_check
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .errors       (errors),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(negedge clk)
        result_stall <= !calm && ($urandom_range(0, 99) < 33);

    function automatic logic [FORCE_W-1:0] rand_force();
        case ($urandom_range(0, 7))
            0:       return F_MIN;
            1:       return F_MAX;
            2:       return {{48{$urandom_range(0, 1) == 1}}, 16'($urandom)};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Mostly a small pool of atoms, so that sums build up before they are read.
    function automatic int rand_atom();
        if ($urandom_range(0, 4) == 0)
            return $urandom_range(0, ATOM_COUNT - 1);
        return $urandom_range(0, 15);
    endfunction

    function automatic int rand_factor();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return Q16_ONE;
            2:       return $urandom_range(Q16_ONE + 1, 2**FACTOR_W - 1);
            default: return $urandom_range(0, Q16_ONE);
        endcase
    endfunction

    function automatic item_t spread_item(int a, int p, int k, logic [FORCE_W-1:0] x,
                                          logic [FORCE_W-1:0] y, logic [FORCE_W-1:0] z);
        item_t it;
        it.cmd           = CMD_SPREAD;
        it.atom_index    = ATOM_W'(a);
        it.partner_index = ATOM_W'(p);
        it.keep_factor   = FACTOR_W'(k);
        it.force_x       = x;
        it.force_y       = y;
        it.force_z       = z;
        return it;
    endfunction

    // The fields a read does not use carry random values.
    function automatic item_t read_item(int a);
        item_t it;
        it            = spread_item($urandom_range(0, ATOM_COUNT - 1),
                                    $urandom_range(0, ATOM_COUNT - 1),
                                    $urandom_range(0, 2**FACTOR_W - 1),
                                    rand_force(), rand_force(), rand_force());
        it.cmd        = CMD_READ;
        it.atom_index = ATOM_W'(a);
        return it;
    endfunction

    task automatic send(input item_t it);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 33)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    initial
    begin
        int a;
        int p;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        result_stall = 1'b0;
        calm         = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Extreme factors, including ones above one that must saturate.
        send(spread_item(0, 1, 0, F_MAX, F_MIN, F_ONES));
        send(spread_item(0, 1, Q16_ONE, F_MIN, F_MAX, 64'd1));
        send(spread_item(2, 3, Q16_ONE - 1, F_MAX, F_MIN, -64'sd65537));
        send(spread_item(2, 3, 1, F_MIN, 64'd65535, F_ONES));
        send(spread_item(4, 5, 2**FACTOR_W - 1, F_MAX, F_MIN, 64'd123456789));
        send(spread_item(4, 5, Q16_ONE + 1, -64'sd3, 64'd3, F_MIN));
        send(spread_item(6, 7, Q16_ONE / 2, -64'sd1, 64'd1, -64'sd65536));
        // Partner equal to atom: the whole force lands, the factor is ignored.
        send(spread_item(8, 8, 12345, F_MAX, F_MIN, F_ONES));
        send(spread_item(9, 9, 0, F_MAX, F_MAX, F_MIN));
        send(spread_item(9, 9, 2**FACTOR_W - 1, F_MAX, F_MAX, F_MIN));
        send(spread_item(ATOM_COUNT - 1, 0, 40000, F_ONES, F_MAX, F_MIN));
        send(spread_item(0, ATOM_COUNT - 1, 25000, F_MIN, F_ONES, F_MAX));
        send(read_item(0));
        send(read_item(0));
        send(read_item(1));
        send(read_item(2));
        send(read_item(3));
        send(read_item(4));
        send(read_item(5));
        send(read_item(7));
        send(read_item(8));
        send(read_item(9));
        send(read_item(ATOM_COUNT - 1));
        send(read_item(2000));

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // A stretch with neither side idling.
            calm <= (n >= 250 && n < 350);
            if ($urandom_range(0, 3) == 0)
                send(read_item(rand_atom()));
            else
            begin
                a = rand_atom();
                p = ($urandom_range(0, 6) == 0) ? a : rand_atom();
                send(spread_item(a, p, rand_factor(), rand_force(), rand_force(),
                                 rand_force()));
            end
        end
        @(negedge clk);
        item_valid <= 1'b0;
        calm       <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
